FILE: hdl/switch_debounce_tap_detect_assert.svh
// assertion macros for the switch debounce and tap detect block
`ifndef SWITCH_DEBOUNCE_TAP_DETECT_ASSERT_SVH
`define SWITCH_DEBOUNCE_TAP_DETECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define SDTD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdtd assertion failed");

// next-cycle implication, checked out of reset
`define SDTD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdtd assertion failed");

`else

`define SDTD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SDTD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/sdtd_pkg.sv
// shared types and constants for the switch debounce and tap detect block
package sdtd_pkg;

    localparam int PIN_W    = 5;
    localparam int CNT_W    = 8;
    localparam int FLAG_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [CNT_W-1:0] FIRE_SAT = 8'd250;

    // user bank bit positions
    localparam int POWER_BIT = 0;
    localparam int SONG_BIT  = 2;
    localparam int FIRE_BIT  = 3;

    // event flag bit positions
    localparam int FLAG_HELD  = 0;
    localparam int FLAG_TAP   = 1;
    localparam int FLAG_SONG  = 2;
    localparam int FLAG_POWER = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIP_SELECT_MASK      = 3'd0,
        CFG_DIP_SELECT_TAP_VALUE = 3'd1,
        CFG_DIP_HEAT_MASK        = 3'd2,
        CFG_DIP_DEBOUNCE_TICKS   = 3'd3,
        CFG_SWITCH_DEBOUNCE_TICKS = 3'd4,
        CFG_TAP_MIN_TICKS        = 3'd5,
        CFG_TAP_MAX_TICKS        = 3'd6
    } cfg_index_t;

    localparam logic [PIN_W-1:0] RST_DIP_SELECT_MASK      = 5'd3;
    localparam logic [PIN_W-1:0] RST_DIP_SELECT_TAP_VALUE = 5'd2;
    localparam logic [PIN_W-1:0] RST_DIP_HEAT_MASK        = 5'd4;
    localparam logic [CNT_W-1:0] RST_DIP_DEBOUNCE_TICKS   = 8'd10;
    localparam logic [CNT_W-1:0] RST_SWITCH_DEBOUNCE_TICKS = 8'd15;
    localparam logic [CNT_W-1:0] RST_TAP_MIN_TICKS        = 8'd12;
    localparam logic [CNT_W-1:0] RST_TAP_MAX_TICKS        = 8'd30;

    // per-bank debounce tracking state
    typedef struct packed {
        logic [PIN_W-1:0] cand;
        logic [CNT_W-1:0] cnt;
    } deb_state_t;

endpackage

FILE: hdl/switch_debounce_tap_detect.sv
// top level: switch bank debounce, fire tap and hold timing, sticky events
//
//  channel | dir | fields (lsb first)
//  --------+-----+---------------------------------------------------------------
//  s_      | in  | dip_pins[4:0] user_pins[9:5] clear_tap/song/power [12:10]
//  m_      | out | dip_setting, switch_setting, held, tapped, song, power, pressed
//  cfg_    | in  | write enable, register index, 8-bit data
//
// one request per cycle; each request updates all state in the cycle it is taken
// and its result appears in the output register on the next cycle
// the output register decouples the sides: a new request is taken whenever the
// result register is empty or being drained
// aresetn (synchronous) clears all tracking state and restores register defaults
`include "switch_debounce_tap_detect_assert.svh"

module switch_debounce_tap_detect
    import sdtd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // dip_pins[4:0], user_pins[9:5], clear_tap_request[10],
    // clear_song_request[11], clear_power_request[12], zero [15:13]
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // dip_setting[4:0], switch_setting[9:5], fire_held[10], fire_tapped[11],
    // song_changed[12], power_requested[13], fire_pressed[14], zero [15]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [PIN_W-1:0] sel_mask_reg;
    logic [PIN_W-1:0] sel_tap_reg;
    logic [PIN_W-1:0] heat_mask_reg;
    logic [CNT_W-1:0] dip_ticks_reg;
    logic [CNT_W-1:0] sw_ticks_reg;
    logic [CNT_W-1:0] tap_min_reg;
    logic [CNT_W-1:0] tap_max_reg;

    // tracking state
    logic [PIN_W-1:0]  dip_stable_reg, dip_stable_next;
    deb_state_t        dip_deb_reg, dip_deb_next;
    logic [PIN_W-1:0]  sw_stable_reg, sw_stable_next;
    deb_state_t        sw_deb_reg, sw_deb_next;
    logic [CNT_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             s_accept;
    logic [PIN_W-1:0] dip_raw;
    logic [PIN_W-1:0] user_raw;
    logic             clr_tap;
    logic             clr_song;
    logic             clr_power;
    logic             dip_accept;
    logic             sw_accept;
    logic [PIN_W-1:0] sel;
    logic             fire_enabled;
    logic [PIN_W-1:0] sw_mid;
    logic [CNT_W-1:0] fire_inc;
    logic             fire_pressed;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // pins are active low
    assign dip_raw   = ~s_tdata[PIN_W-1:0];
    assign user_raw  = ~s_tdata[2*PIN_W-1:PIN_W];
    assign clr_tap   = s_tdata[2*PIN_W];
    assign clr_song  = s_tdata[2*PIN_W+1];
    assign clr_power = s_tdata[2*PIN_W+2];

    sdtd_debounce u_dip_deb (
        .raw        (dip_raw),
        .stable     (dip_stable_reg),
        .state      (dip_deb_reg),
        .ticks      (dip_ticks_reg),
        .state_next (dip_deb_next),
        .accept     (dip_accept)
    );

    assign dip_stable_next = dip_accept ? dip_raw : dip_stable_reg;
    assign sel = dip_stable_next & sel_mask_reg;
    assign fire_enabled = (sel == sel_tap_reg) ||
                          ((sel == sel_mask_reg) && ((dip_stable_next & heat_mask_reg) != '0));
    assign fire_inc = (fire_cnt_reg < FIRE_SAT) ? fire_cnt_reg + CNT_W'(1) : fire_cnt_reg;

    // release inside the window drops the debounced fire bit
    always_comb begin
        sw_mid = sw_stable_reg;
        if (fire_enabled && !user_raw[FIRE_BIT] &&
            fire_cnt_reg >= tap_min_reg && fire_cnt_reg <= tap_max_reg) begin
            sw_mid[FIRE_BIT] = 1'b0;
        end
    end

    // user bank debounce sees the stable pattern after a tap has dropped fire
    sdtd_debounce u_sw_deb (
        .raw        (user_raw),
        .stable     (sw_mid),
        .state      (sw_deb_reg),
        .ticks      (sw_ticks_reg),
        .state_next (sw_deb_next),
        .accept     (sw_accept)
    );

    always_comb begin
        flags_next = flags_reg;
        if (clr_tap) begin
            flags_next[FLAG_HELD] = 1'b0;
            flags_next[FLAG_TAP]  = 1'b0;
        end
        if (clr_song) begin
            flags_next[FLAG_SONG] = 1'b0;
        end
        if (clr_power) begin
            flags_next[FLAG_POWER] = 1'b0;
        end

        fire_cnt_next = '0;
        if (fire_enabled) begin
            if (user_raw[FIRE_BIT]) begin
                fire_cnt_next = fire_inc;
                if (fire_inc == tap_min_reg) begin
                    flags_next[FLAG_HELD] = 1'b1;
                end else if (fire_inc == tap_max_reg) begin
                    flags_next[FLAG_HELD] = 1'b0;
                    flags_next[FLAG_TAP]  = 1'b0;
                end
            end else if (fire_cnt_reg >= tap_min_reg && fire_cnt_reg <= tap_max_reg) begin
                // release inside the window counts as a tap
                flags_next[FLAG_TAP] = 1'b1;
            end
        end else begin
            flags_next[FLAG_HELD] = 1'b0;
            flags_next[FLAG_TAP]  = 1'b0;
        end

        sw_stable_next = sw_mid;
        if (sw_accept) begin
            if (user_raw[SONG_BIT] != sw_mid[SONG_BIT]) begin
                flags_next[FLAG_SONG] = 1'b1;
            end
            if (user_raw[POWER_BIT] && !sw_mid[POWER_BIT]) begin
                flags_next[FLAG_POWER] = 1'b1;
            end
            if (!user_raw[POWER_BIT] && sw_mid[POWER_BIT]) begin
                flags_next[FLAG_POWER] = 1'b0;
            end
            sw_stable_next = user_raw;
        end

        fire_pressed = sw_stable_next[FIRE_BIT] && !flags_next[FLAG_HELD];
        m_tdata_next = {1'b0, fire_pressed, flags_next, sw_stable_next, dip_stable_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_mask_reg  <= RST_DIP_SELECT_MASK;
            sel_tap_reg   <= RST_DIP_SELECT_TAP_VALUE;
            heat_mask_reg <= RST_DIP_HEAT_MASK;
            dip_ticks_reg <= RST_DIP_DEBOUNCE_TICKS;
            sw_ticks_reg  <= RST_SWITCH_DEBOUNCE_TICKS;
            tap_min_reg   <= RST_TAP_MIN_TICKS;
            tap_max_reg   <= RST_TAP_MAX_TICKS;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DIP_SELECT_MASK:       sel_mask_reg  <= cfg_wdata[PIN_W-1:0];
                CFG_DIP_SELECT_TAP_VALUE:  sel_tap_reg   <= cfg_wdata[PIN_W-1:0];
                CFG_DIP_HEAT_MASK:         heat_mask_reg <= cfg_wdata[PIN_W-1:0];
                CFG_DIP_DEBOUNCE_TICKS:    dip_ticks_reg <= cfg_wdata;
                CFG_SWITCH_DEBOUNCE_TICKS: sw_ticks_reg  <= cfg_wdata;
                CFG_TAP_MIN_TICKS:         tap_min_reg   <= cfg_wdata;
                CFG_TAP_MAX_TICKS:         tap_max_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_stable_reg <= '0;
            dip_deb_reg    <= '0;
            sw_stable_reg  <= '0;
            sw_deb_reg     <= '0;
            fire_cnt_reg   <= '0;
            flags_reg      <= '0;
        end else if (s_accept) begin
            dip_stable_reg <= dip_stable_next;
            dip_deb_reg    <= dip_deb_next;
            sw_stable_reg  <= sw_stable_next;
            sw_deb_reg     <= sw_deb_next;
            fire_cnt_reg   <= fire_cnt_next;
            flags_reg      <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    `SDTD_ASSERT_IMPL(a_fire_cnt_sat, aclk, aresetn, 1'b1, fire_cnt_reg <= FIRE_SAT)
    `SDTD_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_accept, m_tvalid)
    `SDTD_ASSERT_IMPL(a_dip_cnt_pending, aclk, aresetn, dip_deb_reg.cnt != '0, dip_deb_reg.cand != dip_stable_reg)
    `SDTD_ASSERT_IMPL(a_pressed_not_held, aclk, aresetn, m_tvalid, !(m_tdata[14] && m_tdata[10]))

endmodule

FILE: hdl/sdtd_debounce.sv
// next-state logic for one debounced switch bank
module sdtd_debounce
    import sdtd_pkg::*;
(
    input  logic [PIN_W-1:0] raw,
    input  logic [PIN_W-1:0] stable,
    input  deb_state_t       state,
    input  logic [CNT_W-1:0] ticks,
    output deb_state_t       state_next,
    output logic             accept
);

    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        cnt_base = (raw != state.cand) ? '0 : state.cnt;
        cnt_inc  = cnt_base + CNT_W'(1);
        accept   = 1'b0;
        if (raw == stable) begin
            state_next.cand = state.cand;
            state_next.cnt  = '0;
        end else begin
            state_next.cand = raw;
            // a tick setting of zero accepts after one tick, like one
            if (cnt_inc >= ticks) begin
                accept         = 1'b1;
                state_next.cnt = '0;
            end else begin
                state_next.cnt = cnt_inc;
            end
        end
    end

endmodule
